// File: src/bbr_pkg.sv
`default_nettype none

package bbr_pkg;

    // Line buffer depth default
    localparam int BBR_MAX_WIDTH = 1024;

    // Configuration register map
    localparam int FRAME_WIDTH_BITS  = 11;
    localparam int FRAME_HEIGHT_BITS = 16;
    localparam int CFG_DATA_BITS     = 16;
    localparam int CFG_INDEX_BITS    = 1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 16'd480;

    // Pixel and arithmetic widths
    localparam int CHAN_BITS  = 8;
    localparam int PIXEL_BITS = 3 * CHAN_BITS;
    localparam int SUM_BITS   = 12;   // nine channel values
    localparam int NUM_BITS   = 13;   // 2*sum + count
    localparam int PROD_BITS  = 32;

    // Reciprocals scaled by 2^RECIP_SHIFT, exact for the numerator range
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_BITS  = 20;
    localparam logic [RECIP_BITS-1:0] RECIP_ONE   = 20'd524288;
    localparam logic [RECIP_BITS-1:0] RECIP_THREE = 20'd174763;
    localparam logic [RECIP_BITS-1:0] RECIP_NINE  = 20'd58255;

    typedef logic [PIXEL_BITS-1:0] t_pixel;

    // Odd factor of the divisor
    typedef enum logic [1:0] {
        DIV_BY_ONE   = 2'd0,
        DIV_BY_THREE = 2'd1,
        DIV_BY_NINE  = 2'd2
    } t_div_sel;

    // Item sequencer
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_SUM  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

endpackage

`default_nettype wire

// File: src/box_blur_3x3_rgb.sv
// 3x3 box blur over an RGB pixel stream in raster order.
// Input channel (i_valid / o_ready): i_op = 0 carries a pixel, i_op = 1 a
// drain item. Output channel (o_valid / i_ready): blurred colour and
// o_frame_end on the last pixel of the frame. Configuration channel
// (i_cfg_valid / o_cfg_ready, always ready): index 0 frame width, index 1
// frame height; write only while the block is idle.
// Each result belongs to the pixel one row and one pixel earlier; after the
// last pixel feed width + 1 drain items to flush the frame.
// Timing: one item at a time. An item that yields a result passes through
// accept, line-buffer read/write-back, neighbourhood sum, reciprocal
// multiply and output load in turn. An item without a result ends after the
// read/write-back; a drain item with nothing to drain is taken and dropped.
// The pace is set by the read-modify-write on the two line-buffer RAMs and
// the sum and divide stages behind it.
// Reset: counters and window cleared, size returns to 640 x 480; line
// buffers are not cleared, out-of-frame entries are masked.
// Stall: a waiting result sits in the output register; one more item is
// taken and held at the output stage until the register frees.
`default_nettype none

module box_blur_3x3_rgb
    import bbr_pkg::*;
#(
    parameter int MAX_WIDTH = BBR_MAX_WIDTH
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Input items
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_op,
    input  wire logic [CHAN_BITS-1:0]      i_in_red,
    input  wire logic [CHAN_BITS-1:0]      i_in_green,
    input  wire logic [CHAN_BITS-1:0]      i_in_blue,
    // Result items
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic      [CHAN_BITS-1:0]      o_out_red,
    output logic      [CHAN_BITS-1:0]      o_out_green,
    output logic      [CHAN_BITS-1:0]      o_out_blue,
    output logic                           o_frame_end,
    // Configuration writes
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > FRAME_WIDTH_BITS) ? WW : FRAME_WIDTH_BITS;
    localparam int RW = FRAME_HEIGHT_BITS;
    localparam logic [EW-1:0] MAX_W = EW'(MAX_WIDTH);
    localparam logic [RW-1:0] ROW_MAX = {RW{1'b1}};

    // Configuration
    logic [FRAME_WIDTH_BITS-1:0]  r_frame_width;
    logic [FRAME_HEIGHT_BITS-1:0] r_frame_height;

    // Position counters
    logic [CW-1:0] r_in_col,  n_in_col;
    logic [RW-1:0] r_in_row,  n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [RW-1:0] r_out_row, n_out_row;

    // Sequencer
    t_state r_state, n_state;

    // Item in flight
    t_pixel        r_pixel;
    logic [CW-1:0] r_col;
    logic          r_emit;
    logic          r_up, r_down, r_left, r_right, r_last;

    // Window: row 0 upper, column 2 newest
    t_pixel r_window [3][3];

    // Divide pipeline
    logic [NUM_BITS-1:0]  r_num  [3];
    logic [1:0]           r_shift;
    t_div_sel             r_sel;
    logic [PROD_BITS-1:0] r_prod [3];

    // Output register
    logic                 r_out_valid;
    logic [CHAN_BITS-1:0] r_out_chan [3];
    logic                 r_out_last;

    // Line buffer ports
    t_pixel upper_rd, middle_rd;
    logic   rd_en, wr_en;

    // Accept-time decode
    logic [EW-1:0] w_eff, w_cfg, in_col_inc, out_col_inc;
    logic [RW-1:0] h_eff;
    logic          complete, drain, acc, act, emit;
    logic          in_wrap, up, down, left, right, last;
    logic          out_free;

    // Sum stage
    logic [2:0]          row_ok, col_ok;
    logic [1:0]          rows, cols;
    logic [3:0]          count;
    logic [SUM_BITS-1:0] sum_c [3];

    // Divide stage
    logic [NUM_BITS-1:0]   shifted [3];
    logic [RECIP_BITS-1:0] recip;

    // Effective frame size
    assign w_cfg = EW'(r_frame_width);
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = EW'(1);
        end else if (w_cfg > MAX_W) begin
            w_eff = MAX_W;
        end else begin
            w_eff = w_cfg;
        end
    end
    assign h_eff = (r_frame_height == '0) ? RW'(1) : r_frame_height;

    // Decide what the offered item does
    assign complete    = r_in_row >= h_eff;
    assign drain       = i_op || complete;
    assign acc         = i_valid && o_ready;
    assign act         = acc && !(drain && !complete)
                             && !(drain && r_in_row == '0 && r_in_col == '0);
    assign emit        = (r_in_row >= RW'(2)) || (r_in_row == RW'(1) && r_in_col != '0);
    assign in_col_inc  = EW'(r_in_col) + EW'(1);
    assign in_wrap     = in_col_inc >= w_eff;
    assign out_col_inc = EW'(r_out_col) + EW'(1);
    assign up          = r_out_row != '0;
    assign down        = ({1'b0, r_out_row} + (RW+1)'(1)) < {1'b0, h_eff};
    assign left        = r_out_col != '0;
    assign right       = out_col_inc < w_eff;
    assign last        = !down && !right;

    // Advance counters
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (act) begin
            if (in_wrap) begin
                n_in_col = '0;
                if (r_in_row != ROW_MAX) begin
                    n_in_row = r_in_row + RW'(1);
                end
            end else begin
                n_in_col = in_col_inc[CW-1:0];
            end
            if (emit) begin
                if (last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (!right) begin
                    n_out_col = '0;
                    if (r_out_row != ROW_MAX) begin
                        n_out_row = r_out_row + RW'(1);
                    end
                end else begin
                    n_out_col = out_col_inc[CW-1:0];
                end
            end
        end
    end

    assign out_free = !r_out_valid || i_ready;

    // Sequence one item
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (act) n_state = S_READ;
            end
            S_READ: begin
                n_state = r_emit ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Line buffers: read at accept, write back when the data returns
    assign rd_en = act;
    assign wr_en = (r_state == S_READ);

    bbr_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_upper_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_col),
        .i_wdata (middle_rd),
        .i_re    (rd_en),
        .i_raddr (r_in_col),
        .o_rdata (upper_rd)
    );

    bbr_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_middle_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_col),
        .i_wdata (r_pixel),
        .i_re    (rd_en),
        .i_raddr (r_in_col),
        .o_rdata (middle_rd)
    );

    // Masked neighbourhood sums
    assign row_ok = {r_down, 1'b1, r_up};
    assign col_ok = {r_right, 1'b1, r_left};
    assign rows   = 2'd1 + 2'(r_up) + 2'(r_down);
    assign cols   = 2'd1 + 2'(r_left) + 2'(r_right);
    assign count  = 4'(rows) * 4'(cols);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum_c[k] = '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (row_ok[r] && col_ok[c]) begin
                        sum_c[k] = sum_c[k]
                            + SUM_BITS'(r_window[r][c][CHAN_BITS*(2-k) +: CHAN_BITS]);
                    end
                end
            end
        end
    end

    // Scale by the odd factor of the divisor
    always_comb begin
        case (r_sel)
            DIV_BY_ONE:   recip = RECIP_ONE;
            DIV_BY_THREE: recip = RECIP_THREE;
            DIV_BY_NINE:  recip = RECIP_NINE;
            default:      recip = RECIP_ONE;
        endcase
        for (int k = 0; k < 3; k++) begin
            shifted[k] = r_num[k] >> r_shift;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_window[r][c] <= '0;
                end
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FRAME_WIDTH_BITS-1:0];
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FRAME_HEIGHT_BITS-1:0];
                    default: ;
                endcase
            end
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_state   <= n_state;
            // Shift the window as the line data returns
            if (r_state == S_READ) begin
                for (int r = 0; r < 3; r++) begin
                    r_window[r][0] <= r_window[r][1];
                    r_window[r][1] <= r_window[r][2];
                end
                r_window[0][2] <= upper_rd;
                r_window[1][2] <= middle_rd;
                r_window[2][2] <= r_pixel;
            end
            // Hold the result until taken
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (act) begin
            r_pixel <= drain ? '0 : {i_in_red, i_in_green, i_in_blue};
            r_col   <= r_in_col;
            r_emit  <= emit;
            r_up    <= up;
            r_down  <= down;
            r_left  <= left;
            r_right <= right;
            r_last  <= last;
        end
        if (r_state == S_SUM) begin
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= {sum_c[k], 1'b0} + NUM_BITS'(count);
            end
            r_shift <= 2'd1 + 2'(rows == 2'd2) + 2'(cols == 2'd2);
            case (2'(rows == 2'd3) + 2'(cols == 2'd3))
                2'd0:    r_sel <= DIV_BY_ONE;
                2'd1:    r_sel <= DIV_BY_THREE;
                default: r_sel <= DIV_BY_NINE;
            endcase
        end
        if (r_state == S_DIV) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= {{(PROD_BITS-SUM_BITS){1'b0}}, shifted[k][SUM_BITS-1:0]}
                           * {{(PROD_BITS-RECIP_BITS){1'b0}}, recip};
            end
        end
        if (r_state == S_OUT && out_free) begin
            for (int k = 0; k < 3; k++) begin
                r_out_chan[k] <= r_prod[k][RECIP_SHIFT +: CHAN_BITS];
            end
            r_out_last <= r_last;
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_out_red   = r_out_chan[0];
    assign o_out_green = r_out_chan[1];
    assign o_out_blue  = r_out_chan[2];
    assign o_frame_end = r_out_last;

endmodule

`default_nettype wire

// File: src/bbr_ram.sv
`default_nettype none

module bbr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/bbr_checker.sv
`default_nettype none

module bbr_checker
    import bbr_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_valid,
    input wire logic                      o_ready,
    input wire logic                      i_op,
    input wire logic                      o_valid,
    input wire logic                      i_ready,
    input wire logic [CHAN_BITS-1:0]      o_out_red,
    input wire logic [CHAN_BITS-1:0]      o_out_green,
    input wire logic [CHAN_BITS-1:0]      o_out_blue,
    input wire logic                      o_frame_end
);

    // Stalled result keeps valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result dropped while stalled");

    // Stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            $stable({o_out_red, o_out_green, o_out_blue, o_frame_end}))
        else $error("result changed while stalled");

    // A pixel item occupies the block for the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !i_op) |=> !o_ready)
        else $error("item taken while line buffers busy");

    // No result straight after acceptance
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(i_valid && o_ready && !i_op))
        else $error("result appeared too early");

endmodule

bind box_blur_3x3_rgb bbr_checker u_bbr_checker (.*);

`default_nettype wire
